// ----- design/itm_pkg.sv -----
// Shared types and constants for the interval timer with RTC ticks.
// Holds the item, result and register-write structs used by the top level and the timer core.
// No dependencies.
package itm_pkg;

	localparam int DATA_W     = 32;
	localparam int APB_ADDR_W = 3;
	localparam int CODE_W     = 7;
	localparam int KIND_W     = 2;

	// Item kinds.
	localparam logic [KIND_W-1:0] KIND_CMD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ITICK = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RTC   = 2'd2;

	// Bit positions inside a timer command code.
	localparam int CODE_SRC_BIT   = 1;
	localparam int CODE_REL_BIT   = 2;
	localparam int CODE_START_BIT = 4;

	// Register indexes (word address bit paddr[2]).
	localparam logic REG_ITM_EN = 1'b0;
	localparam logic REG_RTC_EN = 1'b1;

	typedef struct packed {
		logic [KIND_W-1:0]        cmd;
		logic [CODE_W-1:0]        code;
		logic signed [DATA_W-1:0] count;
		logic                     int_enab;
		logic                     spad_enab;
		logic                     int_act;
		logic                     spad_act;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic                     itm_irq;
		logic                     rtc_irq;
	} result_t;

	typedef struct packed {
		logic we_itm;
		logic we_rtc;
		logic data;
	} cfg_wr_t;

endpackage

// ----- design/itm_timer.sv -----
// Timer core: command decode, tick handling, interrupt gating and the timer state.
// Also holds the two enable registers, since a write of the timer enable clears the timer.
// Depends on itm_pkg.
module itm_timer import itm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	input  cfg_wr_t cfg,
	output result_t res,
	output logic    itm_en,
	output logic    rtc_en
);

	typedef enum logic [3:0] {
		OP_NONE,
		OP_STOP,
		OP_LOAD,
		OP_RESTART,
		OP_LOADSTART,
		OP_READ,
		OP_READSTOP,
		OP_READLOAD,
		OP_READLOADSTART
	} op_t;

	logic signed [DATA_W-1:0] counter_q, counter_d;
	logic signed [DATA_W-1:0] reload_q, reload_d;
	logic running_q, running_d;
	logic armed_q, armed_d;
	logic source_q, source_d;
	logic relmode_q, relmode_d;
	logic itm_en_q, rtc_en_q;

	op_t  op;
	logic src, rel, gate, tick_sel, expire;

	always_comb begin
		unique case (item.code) inside
			7'h20:                                 op = OP_STOP;
			[7'h28:7'h2b], [7'h38:7'h3b]:          op = OP_LOAD;
			[7'h30:7'h32], [7'h34:7'h37],
			[7'h70:7'h72], [7'h74:7'h76]:          op = OP_RESTART;
			[7'h3c:7'h3e]:                         op = OP_LOADSTART;
			7'h40:                                 op = OP_READ;
			7'h60:                                 op = OP_READSTOP;
			[7'h68:7'h6a]:                         op = OP_READLOAD;
			[7'h78:7'h7f]:                         op = OP_READLOADSTART;
			default:                               op = OP_NONE;
		endcase
	end

	assign src  = item.code[CODE_SRC_BIT];
	assign rel  = item.code[CODE_REL_BIT];
	assign gate = (item.int_enab | item.spad_enab) & (~item.int_act | ~item.spad_act);
	assign tick_sel = ((item.cmd == KIND_ITICK) & ~source_q) |
		((item.cmd == KIND_RTC) & source_q);
	// The count runs out when it is at one or below before the tick.
	assign expire = armed_q & (counter_q <= $signed(DATA_W'(1)));

	always_comb begin
		counter_d = counter_q;
		reload_d  = reload_q;
		running_d = running_q;
		armed_d   = armed_q;
		source_d  = source_q;
		relmode_d = relmode_q;
		res       = '0;
		case (item.cmd)
			KIND_CMD: begin
				unique case (op)
					OP_STOP: begin
						running_d = 1'b0;
						armed_d   = 1'b0;
						reload_d  = '0;
					end
					OP_LOAD: begin
						counter_d = item.count;
						running_d = item.code[CODE_START_BIT];
						armed_d   = item.code[CODE_START_BIT];
						if (item.code[CODE_START_BIT]) begin
							source_d = src;
						end
						reload_d = '0;
					end
					OP_RESTART: begin
						res.read_value = counter_q;
						running_d = 1'b1;
						armed_d   = 1'b1;
						source_d  = src;
						reload_d  = rel ? counter_q : '0;
					end
					OP_LOADSTART: begin
						counter_d = item.count;
						running_d = 1'b1;
						armed_d   = 1'b1;
						source_d  = src;
						if (rel) begin
							reload_d = item.count;
						end
					end
					OP_READ: begin
						res.read_value = counter_q;
					end
					OP_READSTOP: begin
						res.read_value = counter_q;
						running_d = 1'b0;
						armed_d   = 1'b0;
						reload_d  = '0;
					end
					OP_READLOAD: begin
						res.read_value = counter_q;
						counter_d = item.count;
						source_d  = src;
						running_d = 1'b0;
						armed_d   = 1'b0;
						reload_d  = '0;
					end
					OP_READLOADSTART: begin
						res.read_value = counter_q;
						counter_d = item.count;
						running_d = 1'b1;
						armed_d   = 1'b1;
						source_d  = src;
						reload_d  = rel ? item.count : '0;
					end
					default: begin
					end
				endcase
				if (op != OP_NONE) begin
					relmode_d = rel;
				end
			end
			KIND_ITICK, KIND_RTC: begin
				if (item.cmd == KIND_RTC) begin
					res.rtc_irq = rtc_en_q & gate;
				end
				if (running_q && tick_sel) begin
					counter_d = counter_q - $signed(DATA_W'(1));
					if (expire) begin
						armed_d = 1'b0;
						if (itm_en_q) begin
							res.itm_irq = gate;
							// Reload keeps the timer armed for the next period.
							if (item.int_enab && relmode_q && reload_q != '0) begin
								counter_d = reload_q;
								armed_d   = 1'b1;
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			reload_q  <= '0;
			running_q <= 1'b0;
			armed_q   <= 1'b0;
			source_q  <= 1'b0;
			relmode_q <= 1'b0;
			itm_en_q  <= 1'b0;
			rtc_en_q  <= 1'b0;
		end else begin
			if (cfg.we_rtc) begin
				rtc_en_q <= cfg.data;
			end
			if (cfg.we_itm) begin
				itm_en_q  <= cfg.data;
				counter_q <= '0;
				reload_q  <= '0;
				running_q <= 1'b0;
				armed_q   <= 1'b0;
				source_q  <= 1'b0;
			end else if (fire) begin
				counter_q <= counter_d;
				reload_q  <= reload_d;
				running_q <= running_d;
				armed_q   <= armed_d;
				source_q  <= source_d;
				relmode_q <= relmode_d;
			end
		end
	end

	assign itm_en = itm_en_q;
	assign rtc_en = rtc_en_q;

	a_rtc_irq_src: assert property (@(posedge clk) disable iff (!arst_n)
		res.rtc_irq |-> (item.cmd == KIND_RTC) && rtc_en_q)
		else $error("clock interrupt without an enabled RTC tick");

	a_itm_irq_src: assert property (@(posedge clk) disable iff (!arst_n)
		res.itm_irq |-> itm_en_q && running_q && armed_q && tick_sel)
		else $error("timer interrupt without an armed, running timer");

	a_stop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !cfg.we_itm && (item.cmd == KIND_CMD) && (op == OP_STOP)
		|=> !running_q && !armed_q && (reload_q == '0))
		else $error("stop request left the timer running");

	a_armed_running: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |-> running_q)
		else $error("timer armed while stopped");

endmodule

// ----- design/interval_timer_with_rtc_ticks.sv -----
// Interval timer with real-time-clock ticks. Each request is a timer command, an interval
// clock tick or an RTC tick and produces exactly one result; the request is held in the input
// register, then its result in the result register at the outputs. The timer update
// is a single 32-bit decrement or load, so one request is taken every clock cycle; the input
// stalls only while the result register is full and stalled. Configuration: register 0 (byte
// address 0) is the interval timer interrupt enable, and any write to it also stops and clears
// the timer; register 1 (byte address 4) is the RTC interrupt enable. Write configuration only
// while idle.
// Depends on itm_pkg and itm_timer.
module interval_timer_with_rtc_ticks import itm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_W-1:0]    paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [KIND_W-1:0]        cmd,
	input  logic [CODE_W-1:0]        code,
	input  logic signed [DATA_W-1:0] count,
	input  logic                     int_enab,
	input  logic                     spad_enab,
	input  logic                     int_act,
	input  logic                     spad_act,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] read_value,
	output logic                     itm_irq,
	output logic                     rtc_irq
);

	item_t   item_s1;
	logic    valid_s1;
	result_t res_q, res_d;
	logic    out_valid_q;
	logic    accept, advance, wr;
	cfg_wr_t cfg;
	logic    itm_en, rtc_en;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign cfg.we_itm = wr & (paddr[2] == REG_ITM_EN);
	assign cfg.we_rtc = wr & (paddr[2] == REG_RTC_EN);
	assign cfg.data   = pwdata[0];
	assign prdata = {{(DATA_W-1){1'b0}}, (paddr[2] == REG_RTC_EN) ? rtc_en : itm_en};

	assign advance  = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall = valid_s1 & ~advance;
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= accept | (valid_s1 & ~advance);
			out_valid_q <= advance | (out_valid_q & out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.cmd       <= cmd;
			item_s1.code      <= code;
			item_s1.count     <= count;
			item_s1.int_enab  <= int_enab;
			item_s1.spad_enab <= spad_enab;
			item_s1.int_act   <= int_act;
			item_s1.spad_act  <= spad_act;
		end
		if (advance) begin
			res_q <= res_d;
		end
	end

	itm_timer u_timer (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_d),
		.itm_en (itm_en),
		.rtc_en (rtc_en)
	);

	assign out_valid  = out_valid_q;
	assign read_value = res_q.read_value;
	assign itm_irq    = res_q.itm_irq;
	assign rtc_irq    = res_q.rtc_irq;

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("request advanced but no result was produced");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("held request was lost or changed");

	a_stall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a full, stalled result register");

endmodule
